FILE: hw/rtl/yuv2rgb_pkg.sv
package yuv2rgb_pkg;

    localparam int K_PIXELS   = 2;
    localparam int K_CHANNELS = 3 * K_PIXELS;
    localparam int K_SUM_W    = 21;
    localparam int K_PROD_W   = 31;

    localparam logic signed [8:0] K_LUMA_OFS   = 9'sd16;
    localparam logic signed [8:0] K_CHROMA_OFS = 9'sd128;

    localparam logic signed [K_SUM_W-1:0] K_COEF_Y  = 21'sd1164;
    localparam logic signed [K_SUM_W-1:0] K_COEF_RV = 21'sd1596;
    localparam logic signed [K_SUM_W-1:0] K_COEF_GU = 21'sd391;
    localparam logic signed [K_SUM_W-1:0] K_COEF_GV = 21'sd813;
    localparam logic signed [K_SUM_W-1:0] K_COEF_BU = 21'sd2018;

    localparam int K_SCALE    = 1000;
    localparam int K_CHAN_MAX = 255;
    localparam logic signed [K_SUM_W-1:0] K_SAT_LIMIT = K_SUM_W'((K_CHAN_MAX + 1) * K_SCALE);

    // Division by 1000 is a shift by three and then a multiply by the
    // reciprocal of 125, which is exact for every quotient below 256.
    localparam int K_RECIP_SHIFT = 22;
    localparam logic [15:0] K_RECIP = 16'((2 ** K_RECIP_SHIFT + 124) / 125);

    localparam int K_CH_R = 0;
    localparam int K_CH_G = 1;
    localparam int K_CH_B = 2;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] chroma_blue;
        logic [7:0] luma_second;
        logic [7:0] chroma_red;
        logic       frame_end;
    } t_yuyv_group;

    typedef struct packed {
        logic [7:0] red_first;
        logic [7:0] green_first;
        logic [7:0] blue_first;
        logic [7:0] red_second;
        logic [7:0] green_second;
        logic [7:0] blue_second;
        logic       frame_end_out;
    } t_rgb_pair;

endpackage

FILE: hw/rtl/yuv2rgb_ifs.sv
interface yuv2rgb_in_if;
    import yuv2rgb_pkg::*;

    logic        valid;
    logic        ready;
    t_yuyv_group data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface yuv2rgb_out_if;
    import yuv2rgb_pkg::*;

    logic      valid;
    logic      ready;
    t_rgb_pair data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/yuyv_to_rgb_converter_unit.sv
// Converts one YUYV group per transfer into two BT.601 RGB pixels that share
// its chroma, with the end-of-frame mark carried alongside. The pipeline has
// four register stages (products, sums, reciprocal multiply with range
// check, clamp into the output register), and a new group is taken in
// every cycle while the output side keeps taking results. When the output
// stalls the whole pipeline holds and input ready drops.
module yuyv_to_rgb_converter_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    yuv2rgb_in_if.sink     i_yuyv,
    yuv2rgb_out_if.source  o_rgb
);
    import yuv2rgb_pkg::*;

    logic w_adv;

    logic                      r1_v, r2_v, r3_v, r4_v;
    logic                      r1_fe, r2_fe, r3_fe;
    logic signed [K_SUM_W-1:0] r1_yt [K_PIXELS];
    logic signed [K_SUM_W-1:0] r1_rv, r1_gu, r1_gv, r1_bu;
    logic signed [K_SUM_W-1:0] r2_sum [K_CHANNELS];
    logic [K_PROD_W-1:0]       r3_prod [K_CHANNELS];
    logic                      r3_low [K_CHANNELS];
    logic                      r3_high [K_CHANNELS];
    t_rgb_pair                 r4_data;

    logic signed [8:0]         n1_yoff [K_PIXELS];
    logic signed [8:0]         n1_uoff, n1_voff;
    logic signed [K_SUM_W-1:0] n1_yt [K_PIXELS];
    logic signed [K_SUM_W-1:0] n2_sum [K_CHANNELS];
    logic [K_PROD_W-1:0]       n3_prod [K_CHANNELS];
    logic                      n3_low [K_CHANNELS];
    logic                      n3_high [K_CHANNELS];
    logic [7:0]                n4_chan [K_CHANNELS];

    assign w_adv        = !r4_v || o_rgb.ready;
    assign i_yuyv.ready = w_adv;
    assign o_rgb.valid  = r4_v;
    assign o_rgb.data   = r4_data;

    always_comb begin
        n1_yoff[0] = $signed({1'b0, i_yuyv.data.luma_first}) - K_LUMA_OFS;
        n1_yoff[1] = $signed({1'b0, i_yuyv.data.luma_second}) - K_LUMA_OFS;
        n1_uoff    = $signed({1'b0, i_yuyv.data.chroma_blue}) - K_CHROMA_OFS;
        n1_voff    = $signed({1'b0, i_yuyv.data.chroma_red}) - K_CHROMA_OFS;
        for (int p = 0; p < K_PIXELS; p++) begin
            n1_yt[p] = K_SUM_W'(n1_yoff[p]) * K_COEF_Y;
        end
    end

    always_comb begin
        for (int p = 0; p < K_PIXELS; p++) begin
            n2_sum[3 * p + K_CH_R] = r1_yt[p] + r1_rv;
            n2_sum[3 * p + K_CH_G] = r1_yt[p] - r1_gu - r1_gv;
            n2_sum[3 * p + K_CH_B] = r1_yt[p] + r1_bu;
        end
    end

    always_comb begin
        for (int c = 0; c < K_CHANNELS; c++) begin
            n3_low[c]  = r2_sum[c][K_SUM_W-1];
            n3_high[c] = !r2_sum[c][K_SUM_W-1] && (r2_sum[c] >= K_SAT_LIMIT);
            n3_prod[c] = K_PROD_W'(r2_sum[c][17:3]) * K_PROD_W'(K_RECIP);
        end
    end

    always_comb begin
        for (int c = 0; c < K_CHANNELS; c++) begin
            if (r3_low[c]) begin
                n4_chan[c] = 8'd0;
            end else if (r3_high[c]) begin
                n4_chan[c] = 8'(K_CHAN_MAX);
            end else begin
                n4_chan[c] = r3_prod[c][K_RECIP_SHIFT +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (w_adv) begin
            r1_v <= i_yuyv.valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_yt  <= n1_yt;
            r1_rv  <= K_SUM_W'(n1_voff) * K_COEF_RV;
            r1_gu  <= K_SUM_W'(n1_uoff) * K_COEF_GU;
            r1_gv  <= K_SUM_W'(n1_voff) * K_COEF_GV;
            r1_bu  <= K_SUM_W'(n1_uoff) * K_COEF_BU;
            r1_fe  <= i_yuyv.data.frame_end;
            r2_sum <= n2_sum;
            r2_fe  <= r1_fe;
            r3_prod <= n3_prod;
            r3_low  <= n3_low;
            r3_high <= n3_high;
            r3_fe   <= r2_fe;
            r4_data.red_first     <= n4_chan[K_CH_R];
            r4_data.green_first   <= n4_chan[K_CH_G];
            r4_data.blue_first    <= n4_chan[K_CH_B];
            r4_data.red_second    <= n4_chan[3 + K_CH_R];
            r4_data.green_second  <= n4_chan[3 + K_CH_G];
            r4_data.blue_second   <= n4_chan[3 + K_CH_B];
            r4_data.frame_end_out <= r3_fe;
        end
    end

endmodule

FILE: dv/yuyv_to_rgb_converter_unit_tb.sv
module yuyv_to_rgb_converter_unit_tb;
    import yuv2rgb_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_GROUPS = 734;
    localparam int MAX_GAP      = 13;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AT      = 250;
    localparam int DRAIN_CYCLES = 16;
    localparam int IDLE_LIMIT   = 2000;
    localparam int MAX_PRINTED  = 50;

    // BT.601 video-range coefficients, scaled by a thousand.
    localparam int MUL_Y   = 1164;
    localparam int MUL_RV  = 1596;
    localparam int MUL_GU  = 391;
    localparam int MUL_GV  = 813;
    localparam int MUL_BU  = 2018;
    localparam int DIVISOR = 1000;
    localparam int Y_BASE  = 16;
    localparam int C_BASE  = 128;
    localparam int TOP     = 255;

    logic clk;
    logic rst_n = 1'b0;

    yuv2rgb_in_if  in_if ();
    yuv2rgb_out_if out_if ();

    yuyv_to_rgb_converter_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_yuyv  (in_if),
        .o_rgb   (out_if)
    );

    class rgb_pair_scoreboard;
        t_rgb_pair   pending_pairs[$];
        int unsigned n_errors  = 0;
        int unsigned n_checked = 0;

        static function logic [7:0] clamp_channel(int scaled);
            int q;
            q = scaled / DIVISOR;
            if (q < 0) begin
                q = 0;
            end else if (q > TOP) begin
                q = TOP;
            end
            return q[7:0];
        endfunction

        static function t_rgb_pair convert_group(t_yuyv_group g);
            t_rgb_pair p;
            int        u;
            int        v;
            int        y0;
            int        y1;
            u  = int'(g.chroma_blue) - C_BASE;
            v  = int'(g.chroma_red) - C_BASE;
            y0 = MUL_Y * (int'(g.luma_first) - Y_BASE);
            y1 = MUL_Y * (int'(g.luma_second) - Y_BASE);
            p.red_first     = clamp_channel(y0 + MUL_RV * v);
            p.green_first   = clamp_channel(y0 - MUL_GU * u - MUL_GV * v);
            p.blue_first    = clamp_channel(y0 + MUL_BU * u);
            p.red_second    = clamp_channel(y1 + MUL_RV * v);
            p.green_second  = clamp_channel(y1 - MUL_GU * u - MUL_GV * v);
            p.blue_second   = clamp_channel(y1 + MUL_BU * u);
            p.frame_end_out = g.frame_end;
            return p;
        endfunction

        task report(string what);
            n_errors++;
            if (n_errors <= MAX_PRINTED) begin
                $display("[%0t] mismatch: %s", $realtime, what);
            end
        endtask

        task compare_channel(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want) begin
                report($sformatf("pair %0d %s got %0d, expected %0d",
                                 n_checked, name, got, want));
            end
        endtask

        function void note_group(t_yuyv_group g);
            pending_pairs.push_back(convert_group(g));
        endfunction

        task check_pair(t_rgb_pair got);
            t_rgb_pair want;
            if (pending_pairs.size() == 0) begin
                report($sformatf("pair %0d arrived with nothing outstanding", n_checked));
            end else begin
                want = pending_pairs.pop_front();
                compare_channel("red_first", got.red_first, want.red_first);
                compare_channel("green_first", got.green_first, want.green_first);
                compare_channel("blue_first", got.blue_first, want.blue_first);
                compare_channel("red_second", got.red_second, want.red_second);
                compare_channel("green_second", got.green_second, want.green_second);
                compare_channel("blue_second", got.blue_second, want.blue_second);
                if (got.frame_end_out !== want.frame_end_out) begin
                    report($sformatf("pair %0d frame_end_out got %b, expected %b",
                                     n_checked, got.frame_end_out, want.frame_end_out));
                end
            end
            n_checked++;
        endtask
    endclass

    rgb_pair_scoreboard pair_board = new();

    int unsigned hold_cycles = 0;
    int unsigned idle_cycles = 0;

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic t_yuyv_group make_group(logic [7:0] y0, logic [7:0] u,
                                               logic [7:0] y1, logic [7:0] v,
                                               logic fe);
        return t_yuyv_group'({y0, u, y1, v, fe});
    endfunction

    function automatic logic [7:0] pick_edge();
        logic [7:0] edges [12];
        edges = '{8'd0, 8'd1, 8'd15, 8'd16, 8'd17, 8'd127,
                  8'd128, 8'd129, 8'd235, 8'd240, 8'd254, 8'd255};
        return edges[$urandom_range(0, 11)];
    endfunction

    function automatic t_yuyv_group draw_group();
        t_yuyv_group g;
        g = t_yuyv_group'({$urandom, 1'b0});
        case ($urandom_range(0, 3))
            2: begin
                g.luma_first  = 8'($urandom_range(16, 235));
                g.luma_second = 8'($urandom_range(16, 235));
                g.chroma_blue = 8'($urandom_range(16, 240));
                g.chroma_red  = 8'($urandom_range(16, 240));
            end
            3: begin
                g.luma_first  = pick_edge();
                g.luma_second = pick_edge();
                g.chroma_blue = pick_edge();
                g.chroma_red  = pick_edge();
            end
            default: ;
        endcase
        g.frame_end = ($urandom_range(0, 15) == 0);
        return g;
    endfunction

    // The gap is counted in whole cycles with valid low before the transfer.
    task automatic send_group(t_yuyv_group g, int unsigned gap);
        if (gap > 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.data  = g;
        in_if.valid = 1'b1;
        do @(posedge clk); while (in_if.ready !== 1'b1);
        pair_board.note_group(g);
        @(negedge clk);
    endtask

    initial begin
        int unsigned stall;
        int unsigned seen;
        bit          steady;
        seen   = 0;
        steady = 1'b0;
        out_if.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (hold_cycles > 0) begin
                out_if.ready = 1'b0;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
            end
            if (seen % 40 == 0) begin
                steady = ($urandom_range(0, 2) == 0);
            end
            stall = steady ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                out_if.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_if.ready = 1'b1;
            do @(posedge clk); while (out_if.valid !== 1'b1);
            pair_board.check_pair(out_if.data);
            seen++;
            @(negedge clk);
        end
    end

    initial begin
        @(posedge rst_n);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("yuyv_to_rgb_converter_unit regression: fail");
        $finish;
    end

    initial begin
        bit          steady;
        int unsigned gap;
        in_if.valid = 1'b0;
        in_if.data  = '0;
        steady      = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Range ends, black and white, chroma extremes, both clamps, small
        // negative quotients near the offsets and alternating bit patterns.
        send_group(make_group(8'd0, 8'd0, 8'd0, 8'd0, 1'b0), $urandom_range(0, MAX_GAP));
        send_group(make_group(8'd255, 8'd255, 8'd255, 8'd255, 1'b1), 0);
        send_group(make_group(8'd16, 8'd128, 8'd16, 8'd128, 1'b0), 0);
        send_group(make_group(8'd235, 8'd128, 8'd235, 8'd128, 1'b0), 1);
        send_group(make_group(8'd255, 8'd128, 8'd0, 8'd128, 1'b1), 0);
        send_group(make_group(8'd16, 8'd0, 8'd235, 8'd0, 1'b0), 2);
        send_group(make_group(8'd16, 8'd255, 8'd235, 8'd255, 1'b0), 0);
        send_group(make_group(8'd128, 8'd0, 8'd128, 8'd255, 1'b0), 0);
        send_group(make_group(8'd128, 8'd255, 8'd128, 8'd0, 1'b0), 3);
        send_group(make_group(8'd81, 8'd90, 8'd145, 8'd240, 1'b0), 0);
        send_group(make_group(8'd41, 8'd240, 8'd210, 8'd110, 1'b1), 0);
        send_group(make_group(8'd17, 8'd129, 8'd15, 8'd127, 1'b0), 5);
        send_group(make_group(8'd20, 8'd127, 8'd20, 8'd129, 1'b0), 0);
        send_group(make_group(8'd170, 8'd166, 8'd106, 8'd202, 1'b0), 0);
        send_group(make_group(8'd0, 8'd255, 8'd255, 8'd0, 1'b1), 0);
        send_group(make_group(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b0), 0);
        send_group(make_group(8'h55, 8'hAA, 8'hAA, 8'h55, 1'b1), MAX_GAP);

        for (int i = 0; i < RANDOM_GROUPS; i++) begin
            if (i % 50 == 0) begin
                steady = ($urandom_range(0, 2) == 0);
            end
            if (i == HOLD_AT) begin
                hold_cycles = LONG_HOLD;
            end
            if (i >= HOLD_AT && i < HOLD_AT + 60) begin
                gap = 0;
            end else begin
                gap = steady ? 0 : $urandom_range(0, MAX_GAP);
            end
            send_group(draw_group(), gap);
        end
        in_if.valid = 1'b0;

        while (pair_board.pending_pairs.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pair_board.n_errors == 0 && pair_board.pending_pairs.size() == 0) begin
            $display("yuyv_to_rgb_converter_unit regression: pass");
        end else begin
            $display("yuyv_to_rgb_converter_unit regression: fail");
        end
        $finish;
    end

endmodule
